/* design/integer_pixel_zoom_assert.svh */
// Assertion macros used by the integer pixel zoom emit module.
`ifndef INTEGER_PIXEL_ZOOM_ASSERT_SVH
`define INTEGER_PIXEL_ZOOM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IZ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("integer_pixel_zoom: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IZ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("integer_pixel_zoom: assertion failed");

`endif

/* design/izoom_pkg.sv */
// Shared types and constants of the integer pixel zoom.
`timescale 1ns / 1ps

package izoom_pkg;

    localparam int PIX_W      = 8;
    localparam int FACTOR_W   = 4;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int USER_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SHRINK       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_GAPS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    // Effective mode after clamping the factor registers.
    typedef struct packed {
        logic                shrink;
        logic                fill;
        logic [FACTOR_W-1:0] fx;
        logic [FACTOR_W-1:0] fy;
    } zoom_mode_t;

    // One accepted item turned into a run of output words.
    typedef struct packed {
        logic [PIX_W-1:0]    pixel;
        logic [FACTOR_W-1:0] count;
        logic                use_mem;
        logic                holes;
        logic                status;
        logic                eor;
        logic                eof;
    } job_t;

endpackage

/* design/izoom_line_mem.sv */
// Single-port line store with registered read data.
`timescale 1ns / 1ps

module izoom_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        we,
    input  logic [AW-1:0]               addr,
    input  logic [izoom_pkg::PIX_W-1:0] wdata,
    output logic [izoom_pkg::PIX_W-1:0] rdata
);
    import izoom_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/izoom_seq.sv */
// Position counters and per-item decisions; drives the line store and the job queue.
`timescale 1ns / 1ps

module izoom_seq #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_FACTOR = 8,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1),
    parameter int CW = $clog2(MAX_WIDTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  izoom_pkg::zoom_mode_t       mode,
    input  logic [WW-1:0]               w_eff,
    input  logic [HW-1:0]               h_eff,
    input  logic                        in_fire,
    input  logic                        in_op,
    input  logic [izoom_pkg::PIX_W-1:0] in_pix,
    output logic                        mem_en,
    output logic                        mem_we,
    output logic [CW-1:0]               mem_addr,
    output logic [izoom_pkg::PIX_W-1:0] mem_wdata,
    output logic                        job_load,
    output izoom_pkg::job_t             job
);
    import izoom_pkg::*;

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = $clog2(MAX_FACTOR);
    localparam int SW = ((WW > HW) ? WW : HW) + 2;

    logic [CW-1:0] column_count_reg, column_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [PW-1:0] x_phase_reg, x_phase_next;
    logic [PW-1:0] y_phase_reg, y_phase_next;
    logic [PW-1:0] repeats_left_reg, repeats_left_next;
    logic [CW-1:0] replay_position_reg, replay_position_next;

    logic          last_row, last_col, replay_last_col, seq_error, keep;
    logic [RW-1:0] row_adv;
    logic [PW-1:0] y_phase_adv, x_phase_adv;
    logic [SW-1:0] col_ext, row_ext, fx_ext, fy_ext, w_ext, h_ext;

    assign col_ext = SW'(column_count_reg);
    assign row_ext = SW'(row_count_reg);
    assign fx_ext  = SW'(mode.fx);
    assign fy_ext  = SW'(mode.fy);
    assign w_ext   = SW'(w_eff);
    assign h_ext   = SW'(h_eff);

    assign last_row        = row_ext + SW'(1) >= h_ext;
    assign last_col        = col_ext + SW'(1) >= w_ext;
    assign replay_last_col = SW'(replay_position_reg) + SW'(1) >= w_ext;
    assign seq_error       = (!in_op && repeats_left_reg != '0) ||
                             (in_op && repeats_left_reg == '0);
    // Only the origin of a complete block survives decimation.
    assign keep = x_phase_reg == '0 && y_phase_reg == '0 &&
                  col_ext + fx_ext <= w_ext && row_ext + fy_ext <= h_ext;

    // Values for the start of the next input row, and the x phase for the next column.
    assign row_adv     = last_row ? '0 : row_count_reg + RW'(1);
    assign y_phase_adv = (last_row || SW'(y_phase_reg) + SW'(1) >= fy_ext) ?
                         '0 : y_phase_reg + PW'(1);
    assign x_phase_adv = (SW'(x_phase_reg) + SW'(1) >= fx_ext) ?
                         '0 : x_phase_reg + PW'(1);

    always_comb begin
        column_count_next    = column_count_reg;
        row_count_next       = row_count_reg;
        x_phase_next         = x_phase_reg;
        y_phase_next         = y_phase_reg;
        repeats_left_next    = repeats_left_reg;
        replay_position_next = replay_position_reg;
        job                  = '0;
        mem_en               = 1'b0;
        mem_we               = 1'b0;
        mem_addr             = column_count_reg;
        mem_wdata            = in_pix;

        if (seq_error) begin
            job.count  = FACTOR_W'(1);
            job.status = 1'b1;
        end else if (!in_op) begin
            mem_en = 1'b1;
            mem_we = 1'b1;
            if (!mode.shrink) begin
                job.pixel = in_pix;
                job.count = mode.fx;
                job.holes = !mode.fill;
                job.eor   = last_col;
                job.eof   = last_col && mode.fy == FACTOR_W'(1) && last_row;
            end else if (keep) begin
                job.pixel = in_pix;
                job.count = FACTOR_W'(1);
                job.eor   = col_ext + (fx_ext << 1) > w_ext;
                job.eof   = job.eor && (row_ext + (fy_ext << 1) > h_ext);
            end
            if (last_col) begin
                column_count_next = '0;
                x_phase_next      = '0;
                if (!mode.shrink && mode.fy > FACTOR_W'(1)) begin
                    repeats_left_next    = PW'(mode.fy - FACTOR_W'(1));
                    replay_position_next = '0;
                end else begin
                    row_count_next = row_adv;
                    y_phase_next   = y_phase_adv;
                end
            end else begin
                column_count_next = column_count_reg + CW'(1);
                x_phase_next      = x_phase_adv;
            end
        end else begin
            mem_en    = 1'b1;
            mem_addr  = replay_position_reg;
            job.count = mode.fx;
            // Without fill the replayed rows are all holes.
            job.use_mem = mode.fill;
            job.eor   = replay_last_col;
            job.eof   = replay_last_col && repeats_left_reg == PW'(1) && last_row;
            if (replay_last_col) begin
                replay_position_next = '0;
                repeats_left_next    = repeats_left_reg - PW'(1);
                if (repeats_left_reg == PW'(1)) begin
                    row_count_next = row_adv;
                    y_phase_next   = y_phase_adv;
                end
            end else begin
                replay_position_next = replay_position_reg + CW'(1);
            end
        end

        if (!in_fire) begin
            mem_en = 1'b0;
            mem_we = 1'b0;
        end
    end

    assign job_load = in_fire && job.count != '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg    <= '0;
            row_count_reg       <= '0;
            x_phase_reg         <= '0;
            y_phase_reg         <= '0;
            repeats_left_reg    <= '0;
            replay_position_reg <= '0;
        end else if (in_fire) begin
            column_count_reg    <= column_count_next;
            row_count_reg       <= row_count_next;
            x_phase_reg         <= x_phase_next;
            y_phase_reg         <= y_phase_next;
            repeats_left_reg    <= repeats_left_next;
            replay_position_reg <= replay_position_next;
        end
    end

endmodule

/* design/izoom_emit.sv */
// Job register that expands one item into its run of words, and the output register.
`timescale 1ns / 1ps

module izoom_emit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_load,
    input  izoom_pkg::job_t              job_in,
    input  logic [izoom_pkg::PIX_W-1:0]  mem_rdata,
    output logic                         slot_free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [izoom_pkg::PIX_W-1:0]  m_tdata,
    output logic                         m_tlast,
    output logic [izoom_pkg::USER_W-1:0] m_tuser
);
    import izoom_pkg::*;
    `include "integer_pixel_zoom_assert.svh"

    logic              job_valid_reg;
    job_t              job_reg;
    logic              first_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_last_reg;
    logic [USER_W-1:0] out_user_reg;

    logic             out_free, step, final_step;
    logic [PIX_W-1:0] base_pix, word_pix;

    assign out_free   = !out_valid_reg || m_tready;
    assign step       = job_valid_reg && out_free;
    assign final_step = step && job_reg.count == FACTOR_W'(1);
    assign slot_free  = !job_valid_reg || final_step;

    // Read data stays put until the next item is taken, which is never
    // before the last word of the current run has left.
    assign base_pix = job_reg.use_mem ? mem_rdata : job_reg.pixel;
    assign word_pix = (job_reg.holes && !first_reg) ? '0 : base_pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (job_load) begin
                job_valid_reg <= 1'b1;
            end else if (final_step) begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_reg   <= job_in;
            first_reg <= 1'b1;
        end else if (step) begin
            job_reg.count <= job_reg.count - FACTOR_W'(1);
            first_reg     <= 1'b0;
        end
        if (step) begin
            out_pix_reg  <= word_pix;
            out_last_reg <= job_reg.count == FACTOR_W'(1);
            out_user_reg <= {job_reg.status,
                             job_reg.eof && job_reg.count == FACTOR_W'(1),
                             job_reg.eor && job_reg.count == FACTOR_W'(1)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    `IZ_ASSERT_IMP(a_load_when_free, aclk, aresetn, job_load, slot_free)
    `IZ_ASSERT_IMP(a_job_nonempty, aclk, aresetn, job_valid_reg, job_reg.count != '0)
    `IZ_ASSERT_IMP(a_status_alone, aclk, aresetn, out_valid_reg && out_user_reg[2], out_last_reg && out_user_reg[1:0] == '0)
    `IZ_ASSERT_IMP(a_eof_in_eor, aclk, aresetn, out_valid_reg && out_user_reg[1], out_user_reg[0] && out_last_reg)
    `IZ_ASSERT_NXT(a_final_frees, aclk, aresetn, final_step && !job_load, !job_valid_reg)

endmodule

/* design/integer_pixel_zoom.sv */
// Top level of the integer pixel zoom: configuration registers and wiring.
//
// Pixels of a raster frame enter on the s_ channel (tdata: pixel_in, tuser:
// opcode, 0 new pixel, 1 replay step) and zoomed pixels leave on the m_
// channel (tdata: pixel_out, tlast: last word of the item's run, tuser:
// end_of_row, end_of_frame, status). Enlarging gives factor_x words per new
// pixel; the other factor_y-1 output rows are made by replay steps, one per
// stored pixel of the row, read from the line store (zero without fill).
// Shrinking keeps one pixel per complete block; the others give no word.
// Registers are written on the cfg_ channel; the user must write them only
// while the block is idle, which the block itself does not enforce. An
// item's first word goes through the expansion register, then the output
// register. Output runs at one word per cycle while m_tready is high; an
// item producing none never enters the expansion register. The next item
// is taken in the cycle its predecessor's last word is registered. Each new
// pixel writes the line store once and each replay step reads it once. Reset
// clears all counters and restores the register defaults; the line store
// keeps whatever it holds. When m_tready is low the output word holds and
// the input stalls once the expansion register has no free slot.
`timescale 1ns / 1ps

module integer_pixel_zoom #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [izoom_pkg::PIX_W-1:0]      s_tdata,  // [7:0] pixel_in
    input  logic                             s_tuser,  // [0] opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [izoom_pkg::PIX_W-1:0]      m_tdata,  // [7:0] pixel_out
    output logic                             m_tlast,
    output logic [izoom_pkg::USER_W-1:0]     m_tuser,  // [0] end_of_row, [1] end_of_frame, [2] status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [izoom_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [izoom_pkg::CFG_DATA_W-1:0] cfg_data
);
    import izoom_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);

    logic                shrink_reg;
    logic [FACTOR_W-1:0] factor_x_reg, factor_y_reg;
    logic                fill_gaps_reg;
    logic [SIZE_W-1:0]   row_width_reg, frame_height_reg;

    zoom_mode_t       mode;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic             in_fire, cfg_fire, slot_free;
    logic             mem_en, mem_we, job_load;
    logic [CW-1:0]    mem_addr;
    logic [PIX_W-1:0] mem_wdata, mem_rdata;
    job_t             job;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = slot_free;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shrink_reg       <= 1'b0;
            factor_x_reg     <= FACTOR_W'(2);
            factor_y_reg     <= FACTOR_W'(2);
            fill_gaps_reg    <= 1'b1;
            row_width_reg    <= SIZE_W'(640);
            frame_height_reg <= SIZE_W'(480);
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_SHRINK:       shrink_reg       <= cfg_data[0];
                REG_FACTOR_X:     factor_x_reg     <= cfg_data[FACTOR_W-1:0];
                REG_FACTOR_Y:     factor_y_reg     <= cfg_data[FACTOR_W-1:0];
                REG_FILL_GAPS:    fill_gaps_reg    <= cfg_data[0];
                REG_ROW_WIDTH:    row_width_reg    <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one, and anything beyond the supported maximum saturates.
    always_comb begin
        mode.shrink = shrink_reg;
        mode.fill   = fill_gaps_reg;
        if (factor_x_reg == '0) begin
            mode.fx = FACTOR_W'(1);
        end else if (int'(factor_x_reg) > MAX_FACTOR) begin
            mode.fx = FACTOR_W'(MAX_FACTOR);
        end else begin
            mode.fx = factor_x_reg;
        end
        if (factor_y_reg == '0) begin
            mode.fy = FACTOR_W'(1);
        end else if (int'(factor_y_reg) > MAX_FACTOR) begin
            mode.fy = FACTOR_W'(MAX_FACTOR);
        end else begin
            mode.fy = factor_y_reg;
        end
        if (row_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (int'(row_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(row_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = HW'(1);
        end else if (int'(frame_height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(frame_height_reg);
        end
    end

    izoom_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FACTOR (MAX_FACTOR),
        .WW         (WW),
        .HW         (HW),
        .CW         (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .in_fire   (in_fire),
        .in_op     (s_tuser),
        .in_pix    (s_tdata),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .job_load  (job_load),
        .job       (job)
    );

    izoom_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    izoom_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_load  (job_load),
        .job_in    (job),
        .mem_rdata (mem_rdata),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
